// ----- rtl/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared widths, reset constants, types and helpers for the Collatz
// first-descent checker.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // Width of the trajectory register (3x+1 must fit here)
    localparam int TRAJ_WIDTH = 128;
    // Width of step counts and of the step limit register
    localparam int STEP_BITS = 12;
    // Width of the start value as it arrives (high word : low word)
    localparam int LOW_WIDTH = 64;
    localparam int HIGH_WIDTH = 16;
    localparam int START_WIDTH = LOW_WIDTH + HIGH_WIDTH;
    // Width of the saturating failure counter
    localparam int FAIL_WIDTH = 32;

    // Step limit after reset
    localparam logic [STEP_BITS-1:0] STEP_LIMIT_RESET = STEP_BITS'(2000);

    // Result of one shortcut map step plus the descent compare
    typedef struct packed {
        logic [TRAJ_WIDTH-1:0] x_next;   // (3x+1)/2 or x/2
        logic                  overflow; // 3x+1 does not fit
        logic                  below;    // current x below the start value
    } step_res_t;

    // Start value taken modulo 2^TRAJ_WIDTH (zero extended when narrower)
    function automatic logic [TRAJ_WIDTH-1:0] fit_start(
        input logic [START_WIDTH-1:0] start
    );
        logic [TRAJ_WIDTH+START_WIDTH-1:0] ext;
        ext = (TRAJ_WIDTH + START_WIDTH)'(start);
        return ext[TRAJ_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/collatz_first_descent_checker.sv -----
// Sequencing: an accepted item walks in ST_RUN, one map step per cycle
//   through the single shared step unit, then its result is loaded in
//   ST_FINISH once the output register is free; a new start item is taken
//   only in ST_IDLE, so one item is finished before the next is accepted.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, step
//   limit 2000, longest descent and failure count cleared.
// ----------------------------------------------------------------------------
// collatz_first_descent_checker
// Walks the shortcut Collatz map from each start value until it first drops
// below the start, the step limit is hit, or 3x+1 overflows; keeps running
// descent maximum and failure count.
// ----------------------------------------------------------------------------
module collatz_first_descent_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfd_pkg::STEP_BITS-1:0]     cfg_data,
    // start value items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cfd_pkg::LOW_WIDTH-1:0]     s_start_low,
    input  logic [cfd_pkg::HIGH_WIDTH-1:0]    s_start_high,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cfd_pkg::STEP_BITS-1:0]     m_descent_steps,
    output logic                              m_descended,
    output logic                              m_overflowed,
    output logic [cfd_pkg::STEP_BITS-1:0]     m_longest_descent,
    output logic [cfd_pkg::FAIL_WIDTH-1:0]    m_failure_total
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t                            state_reg,      state_next;
    logic [cfd_pkg::STEP_BITS-1:0]     limit_reg,      limit_next;
    logic [cfd_pkg::TRAJ_WIDTH-1:0]    x_reg,          x_next;
    logic [cfd_pkg::TRAJ_WIDTH-1:0]    n_reg,          n_next;
    logic [cfd_pkg::STEP_BITS-1:0]     cnt_reg,        cnt_next;
    logic                              ok_reg,         ok_next;
    logic                              ovf_reg,        ovf_next;
    logic                              m_valid_reg,    m_valid_next;
    logic [cfd_pkg::STEP_BITS-1:0]     m_steps_reg,    m_steps_next;
    logic                              m_ok_reg,       m_ok_next;
    logic                              m_ovf_reg,      m_ovf_next;
    logic [cfd_pkg::STEP_BITS-1:0]     max_reg,        max_next;
    logic [cfd_pkg::FAIL_WIDTH-1:0]    fail_reg,       fail_next;

    cfd_pkg::step_res_t                step_res;
    logic                              out_free;

    // Shared step / compare unit
    cfd_map_step u_step (
        .x         (x_reg),
        .threshold (n_reg),
        .res       (step_res)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_steps_next = m_steps_reg;
        m_ok_next    = m_ok_reg;
        m_ovf_next   = m_ovf_reg;
        max_next     = max_reg;
        fail_next    = fail_reg;

        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = cfd_pkg::fit_start({s_start_high, s_start_low});
                    x_next     = cfd_pkg::fit_start({s_start_high, s_start_low});
                    cnt_next   = '0;
                    ok_next    = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // check descent of the last step, then limit, then overflow, then take a step
                if (cnt_reg != '0 && step_res.below) begin
                    ok_next    = 1'b1;
                    state_next = ST_FINISH;
                end else if (cnt_reg == limit_reg) begin
                    state_next = ST_FINISH;
                end else if (step_res.overflow) begin
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    x_next   = step_res.x_next;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                // load result and update running stats once output is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_ovf_next   = ovf_reg;
                    m_steps_next = ok_reg ? cnt_reg : '0;
                    if (ok_reg) begin
                        if (cnt_reg > max_reg) begin
                            max_next = cnt_reg;
                        end
                    end else if (fail_reg != '1) begin
                        fail_next = fail_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= cfd_pkg::STEP_LIMIT_RESET;
            m_valid_reg <= 1'b0;
            max_reg     <= '0;
            fail_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
            max_reg     <= max_next;
            fail_reg    <= fail_next;
            cnt_reg     <= cnt_next;
        end
        x_reg       <= x_next;
        n_reg       <= n_next;
        ok_reg      <= ok_next;
        ovf_reg     <= ovf_next;
        m_steps_reg <= m_steps_next;
        m_ok_reg    <= m_ok_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_descent_steps   = m_steps_reg;
    assign m_descended       = m_ok_reg;
    assign m_overflowed      = m_ovf_reg;
    assign m_longest_descent = max_reg;
    assign m_failure_total   = fail_reg;

`ifndef SYNTHESIS
    // step count never runs past the limit while walking
    a_cnt_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> cnt_reg <= limit_reg)
        else $error("step count beyond limit");

    // an accepted item starts a walk
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_RUN)
        else $error("accepted item did not start");

    // success and overflow exclude each other
    a_ok_xor_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_descended && m_overflowed))
        else $error("descended and overflowed together");

    // failures report zero steps, successes a nonzero count within the max
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_descended |-> m_descent_steps == '0)
        else $error("failed item with nonzero steps");

    a_ok_in_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_descended |->
            m_descent_steps != '0 && m_descent_steps <= m_longest_descent)
        else $error("descent steps exceed running maximum");
`endif

endmodule

// ----- rtl/cfd_map_step.sv -----
// ----------------------------------------------------------------------------
// cfd_map_step
// Shared arithmetic unit: one shortcut Collatz step on the trajectory
// value, overflow detect, and the compare against the start value.
// ----------------------------------------------------------------------------
module cfd_map_step (
    input  logic [cfd_pkg::TRAJ_WIDTH-1:0] x,
    input  logic [cfd_pkg::TRAJ_WIDTH-1:0] threshold,
    output cfd_pkg::step_res_t             res
);

    // 3x+1 = x + 2x + 1, two guard bits on top
    logic [cfd_pkg::TRAJ_WIDTH+1:0] tri_sum;

    assign tri_sum = {2'b00, x}
                   + {1'b0, x, 1'b0}
                   + {{(cfd_pkg::TRAJ_WIDTH+1){1'b0}}, 1'b1};

    // Odd: halve 3x+1; even: halve x
    always_comb begin
        if (x[0]) begin
            res.x_next   = tri_sum[cfd_pkg::TRAJ_WIDTH:1];
            res.overflow = |tri_sum[cfd_pkg::TRAJ_WIDTH+1:cfd_pkg::TRAJ_WIDTH];
        end else begin
            res.x_next   = {1'b0, x[cfd_pkg::TRAJ_WIDTH-1:1]};
            res.overflow = 1'b0;
        end
        res.below = (x < threshold);
    end

endmodule

// ----- tb/cfd_result_monitor.sv -----
// ----------------------------------------------------------------------------
// cfd_result_monitor
// Watches the config, start and result channels of the Collatz first-descent
// checker. Each accepted start is walked through the shortcut map here, and
// the expected result item is queued. Each accepted result item is compared
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module cfd_result_monitor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cfd_pkg::STEP_BITS-1:0]  cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [cfd_pkg::LOW_WIDTH-1:0]  s_start_low,
    input  logic [cfd_pkg::HIGH_WIDTH-1:0] s_start_high,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [cfd_pkg::STEP_BITS-1:0]  m_descent_steps,
    input  logic                           m_descended,
    input  logic                           m_overflowed,
    input  logic [cfd_pkg::STEP_BITS-1:0]  m_longest_descent,
    input  logic [cfd_pkg::FAIL_WIDTH-1:0] m_failure_total,
    output int                             mismatch_total,
    output int                             descents_pending,
    output int                             results_checked,
    output int                             descents_seen
);

    typedef logic [cfd_pkg::STEP_BITS-1:0]  step_t;
    typedef logic [cfd_pkg::TRAJ_WIDTH-1:0] traj_t;

    // One result item as the block should report it
    typedef struct packed {
        logic [cfd_pkg::STEP_BITS-1:0]  steps;
        logic                           descended;
        logic                           overflowed;
        logic [cfd_pkg::STEP_BITS-1:0]  longest;
        logic [cfd_pkg::FAIL_WIDTH-1:0] failures;
    } descent_res_t;

    // Local copy of the block's register and running statistics
    logic [cfd_pkg::STEP_BITS-1:0]  walk_limit;
    logic [cfd_pkg::STEP_BITS-1:0]  longest_so_far;
    logic [cfd_pkg::FAIL_WIDTH-1:0] failed_so_far;

    // Expected result items, oldest at the read pointer
    descent_res_t expected_fifo [16];
    logic [3:0]   exp_wr_ptr;
    logic [3:0]   exp_rd_ptr;
    int           exp_fill;

    // Walk one start value and fold the outcome into the running statistics
    function automatic descent_res_t walk_to_descent(
        input logic [cfd_pkg::START_WIDTH-1:0] start
    );
        logic [cfd_pkg::TRAJ_WIDTH-1:0] floor_val;
        logic [cfd_pkg::TRAJ_WIDTH-1:0] x;
        logic [cfd_pkg::TRAJ_WIDTH+1:0] tripled;
        descent_res_t                   r;
        int                             k;
        r = '0;
        floor_val = traj_t'(start);
        x = floor_val;
        for (k = 1; k <= int'(walk_limit); k++) begin
            if (x[0]) begin
                tripled = {2'b00, x} * 3 + 1;
                // 3x+1 must fit the trajectory register, else the walk ends
                if (tripled[cfd_pkg::TRAJ_WIDTH+1:cfd_pkg::TRAJ_WIDTH] != 2'b00) begin
                    r.overflowed = 1'b1;
                    break;
                end
                x = tripled[cfd_pkg::TRAJ_WIDTH:1];
            end else begin
                x = x >> 1;
            end
            if (x < floor_val) begin
                r.descended = 1'b1;
                r.steps = step_t'(k);
                break;
            end
        end
        if (r.descended) begin
            if (r.steps > longest_so_far)
                longest_so_far = r.steps;
        end else if (failed_so_far != '1) begin
            failed_so_far = failed_so_far + 1'b1;
        end
        r.longest = longest_so_far;
        r.failures = failed_so_far;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        descent_res_t exp_res;
        if (!aresetn) begin
            walk_limit = cfd_pkg::STEP_LIMIT_RESET;
            longest_so_far = '0;
            failed_so_far = '0;
            exp_wr_ptr = '0;
            exp_rd_ptr = '0;
            exp_fill = 0;
        end else begin
            // config is only written while idle, so order within the edge is safe
            if (cfg_valid && cfg_ready)
                walk_limit = cfg_data;
            if (s_valid && s_ready) begin
                if (exp_fill == 16) begin
                    $display("%0t: start item accepted with too many results due", $time);
                    mismatch_total++;
                end else begin
                    expected_fifo[exp_wr_ptr] = walk_to_descent({s_start_high, s_start_low});
                    exp_wr_ptr = exp_wr_ptr + 4'd1;
                    exp_fill++;
                end
            end
            if (m_valid && m_ready) begin
                if (exp_fill == 0) begin
                    $display("%0t: result item with nothing expected: steps %0d, descended %0d",
                             $time, m_descent_steps, m_descended);
                    mismatch_total++;
                end else begin
                    exp_res = expected_fifo[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 4'd1;
                    exp_fill--;
                    check_field("descent_steps", 64'(exp_res.steps), 64'(m_descent_steps));
                    check_field("descended", 64'(exp_res.descended), 64'(m_descended));
                    check_field("overflowed", 64'(exp_res.overflowed), 64'(m_overflowed));
                    check_field("longest_descent", 64'(exp_res.longest),
                                64'(m_longest_descent));
                    check_field("failure_total", 64'(exp_res.failures),
                                64'(m_failure_total));
                    results_checked++;
                    if (exp_res.descended)
                        descents_seen++;
                end
            end
        end
        descents_pending = exp_fill;
    end

endmodule

// ----- tb/collatz_first_descent_checker_tb.sv -----
// ----------------------------------------------------------------------------
// collatz_first_descent_checker_tb
// Drives start values and step-limit writes into the first-descent checker
// with random gaps and result back-pressure; a monitor beside the block
// predicts and compares every result item. Directed starts cover the field
// extremes and the zero/one and limit-zero cases, then random starts run
// under several step limits.
// ----------------------------------------------------------------------------
module collatz_first_descent_checker_tb;

    typedef logic [cfd_pkg::START_WIDTH-1:0] start_t;
    typedef logic [cfd_pkg::STEP_BITS-1:0]   step_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cfd_pkg::STEP_BITS-1:0]  cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [cfd_pkg::LOW_WIDTH-1:0]  s_start_low;
    logic [cfd_pkg::HIGH_WIDTH-1:0] s_start_high;
    logic                           m_valid;
    logic                           m_ready;
    logic [cfd_pkg::STEP_BITS-1:0]  m_descent_steps;
    logic                           m_descended;
    logic                           m_overflowed;
    logic [cfd_pkg::STEP_BITS-1:0]  m_longest_descent;
    logic [cfd_pkg::FAIL_WIDTH-1:0] m_failure_total;

    int mismatch_total;
    int descents_pending;
    int results_checked;
    int descents_seen;

    int items_sent;
    int limit_writes;
    bit steady_source;
    bit steady_sink;

    collatz_first_descent_checker u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_low       (s_start_low),
        .s_start_high      (s_start_high),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_descent_steps   (m_descent_steps),
        .m_descended       (m_descended),
        .m_overflowed      (m_overflowed),
        .m_longest_descent (m_longest_descent),
        .m_failure_total   (m_failure_total)
    );

    cfd_result_monitor u_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_low       (s_start_low),
        .s_start_high      (s_start_high),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_descent_steps   (m_descent_steps),
        .m_descended       (m_descended),
        .m_overflowed      (m_overflowed),
        .m_longest_descent (m_longest_descent),
        .m_failure_total   (m_failure_total),
        .mismatch_total    (mismatch_total),
        .descents_pending  (descents_pending),
        .results_checked   (results_checked),
        .descents_seen     (descents_seen)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog, sized well past the slowest legal run
    initial begin
        #40_000_000;
        $display("timeout: run did not complete, %0d results still due", descents_pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 80);
    endfunction

    // Result-side back-pressure
    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready = 1'b0;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if (!steady_sink && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Start values: mostly full width, plus small values, long runs of low
    // ones (these climb for many steps) and values near the top
    function automatic start_t pick_start();
        start_t v;
        int     r;
        int     m;
        r = $urandom_range(0, 99);
        v = {16'($urandom), $urandom, $urandom};
        if (r < 55) begin
        end else if (r < 70) begin
            v = start_t'($urandom_range(0, 1023));
        end else if (r < 85) begin
            m = $urandom_range(1, cfd_pkg::START_WIDTH);
            v = (v << m) | ((start_t'(1) << m) - start_t'(1));
        end else if (r < 95) begin
            v[cfd_pkg::START_WIDTH-1:cfd_pkg::LOW_WIDTH] = '0;
        end else begin
            v = '1 - start_t'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // Present one start item and hold it until accepted
    task automatic send_start(input start_t n);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_start_low = n[cfd_pkg::LOW_WIDTH-1:0];
        s_start_high = n[cfd_pkg::START_WIDTH-1:cfd_pkg::LOW_WIDTH];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result item
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (descents_pending != 0)
            @(negedge aclk);
    endtask

    task automatic write_limit(input step_t v);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        limit_writes++;
    endtask

    task automatic random_starts(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_start(pick_start());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_start_low = '0;
        s_start_high = '0;
        items_sent = 0;
        limit_writes = 0;
        steady_source = 1'b0;
        steady_sink = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset limit: zero and one never descend, plus field extremes
        send_start(start_t'(0));
        send_start(start_t'(1));
        send_start(start_t'(2));
        send_start(start_t'(3));
        send_start(start_t'(7));
        send_start(start_t'(27));
        send_start({16'h0000, 64'hFFFF_FFFF_FFFF_FFFF});
        send_start({16'h0001, 64'h0000_0000_0000_0000});
        send_start({16'hFFFF, 64'h0000_0000_0000_0000});
        send_start({16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_start({16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA});
        send_start({16'h5555, 64'h5555_5555_5555_5555});
        send_start({16'h8000, 64'h0000_0000_0000_0000});
        send_start({16'h8000, 64'h0000_0000_0000_0001});

        // Smallest nonzero limit: even starts descend at once, odd ones fail
        write_limit(step_t'(1));
        send_start(start_t'(2));
        send_start(start_t'(3));
        send_start(start_t'(4));

        // Limit zero: no step taken, every start fails without overflow
        write_limit('0);
        send_start(start_t'(5));
        send_start({16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});

        // Largest limit
        write_limit('1);
        send_start(start_t'(0));
        send_start(start_t'(1));
        send_start(start_t'(27));
        send_start({16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});

        // Random starts under a spread of limits, with 80-bit starts; no start
        // here is chosen to provoke overflow.
        write_limit(cfd_pkg::STEP_LIMIT_RESET);
        random_starts(90);

        // Short limits make failures common; no idling on either side
        steady_source = 1'b1;
        steady_sink = 1'b1;
        write_limit(step_t'($urandom_range(1, 40)));
        random_starts(70);

        steady_source = 1'b0;
        steady_sink = 1'b0;
        write_limit('1);
        random_starts(40);

        write_limit(step_t'($urandom_range(41, 700)));
        random_starts(70);

        drain_results();
        repeat (50) @(posedge aclk);

        $display("summary: %0d start items over %0d step-limit settings, %0d results checked",
                 items_sent, limit_writes + 1, results_checked);
        $display("summary: %0d descended, %0d failed", descents_seen,
                 results_checked - descents_seen);
        if (mismatch_total == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- collatz_first_descent_checker.f -----
rtl/cfd_pkg.sv
rtl/cfd_map_step.sv
rtl/collatz_first_descent_checker.sv
tb/cfd_result_monitor.sv
tb/collatz_first_descent_checker_tb.sv
